[rtl/core/lfns_pkg.sv]
// Light frame node statistics: shared types and constants.
// Used by the modules under rtl/core except lfns_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfns_pkg;

  localparam int MaxChannels = 4096;
  localparam int MaxNodes    = 1024;

  localparam int CntW   = 13;              // channel_count / channels_per_node
  localparam int NcW    = 11;              // node_count
  localparam int PosW   = $clog2(MaxChannels);
  localparam int IdxW   = $clog2(MaxNodes);
  localparam int BriW   = 9;               // half-byte brightness 0..510
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [CntW-1:0] MaxChCfg   = CntW'(MaxChannels);
  localparam logic [NcW-1:0]  MaxNodeCfg = NcW'(MaxNodes);

  typedef enum logic [1:0] {
    CfgChannelCount    = 2'd0,
    CfgNodeCount       = 2'd1,
    CfgChannelsPerNode = 2'd2,
    CfgThreshold       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] channel_count;
    logic [NcW-1:0]  node_count;
    logic [CntW-1:0] channels_per_node;
    logic [7:0]      threshold;
  } geom_t;

  // One queue beat: an optional finished node plus frame-end channel stats.
  typedef struct packed {
    logic            node_vld;
    logic [BriW-1:0] bright;
    logic [IdxW-1:0] idx;
    logic            frame_end;
    logic [12:0]     active_channels;
    logic [19:0]     level_sum;
    logic [7:0]      peak_level;
  } qent_t;

  typedef struct packed {
    logic [15:0] frame_number;
    logic [12:0] active_channels;
    logic [19:0] level_sum;
    logic [7:0]  peak_level;
    logic [10:0] active_nodes;
    logic [18:0] brightness_sum;
    logic [27:0] weighted_position_sum;
    logic [9:0]  run_count;
    logic [10:0] longest_run;
    logic [18:0] change_sum;
    logic        change_valid;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/lfns_front.sv]
// Front end: takes channel beats, keeps channel stats, closes nodes.
// Pushes node / frame-end records to the queue. Depends on lfns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfns_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lfns_pkg::geom_t geom_i,
  input  wire logic           clear_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     level_i,
  input  wire logic           q_full_i,
  output logic                q_push_o,
  output lfns_pkg::qent_t     q_ent_o
);

  logic [lfns_pkg::PosW-1:0] pos_q, pos_d;
  logic [lfns_pkg::NcW-1:0]  nidx_q, nidx_d;
  logic [lfns_pkg::PosW-1:0] pin_q, pin_d;
  logic [7:0]                npk_q, npk_d;
  logic [lfns_pkg::BriW-1:0] ntot_q, ntot_d;
  logic [12:0]               act_q, act_d;
  logic [19:0]               lsum_q, lsum_d;
  logic [7:0]                pk_q, pk_d;

  logic [lfns_pkg::CntW-1:0] cc, cpn, pin_n;
  logic [lfns_pkg::NcW-1:0]  nc;
  logic                      acc, last, in_node, node_done;
  logic [7:0]                npk_n;
  logic [lfns_pkg::BriW-1:0] ntot_n, bright;

  always_comb begin
    cc = geom_i.channel_count;
    if (cc == '0) cc = lfns_pkg::CntW'(1);
    else if (cc > lfns_pkg::MaxChCfg) cc = lfns_pkg::MaxChCfg;
    cpn = geom_i.channels_per_node;
    if (cpn == '0) cpn = lfns_pkg::CntW'(1);
    else if (cpn > lfns_pkg::MaxChCfg) cpn = lfns_pkg::MaxChCfg;
    nc = geom_i.node_count;
    if (nc == '0) nc = lfns_pkg::NcW'(1);
    else if (nc > lfns_pkg::MaxNodeCfg) nc = lfns_pkg::MaxNodeCfg;
  end

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign last       = ({1'b0, pos_q} + lfns_pkg::CntW'(1)) >= cc;
  assign in_node    = nidx_q < nc;
  assign pin_n      = {1'b0, pin_q} + lfns_pkg::CntW'(1);
  assign npk_n      = (level_i > npk_q) ? level_i : npk_q;
  assign ntot_n     = (cpn < lfns_pkg::CntW'(3)) ? ntot_q + {1'b0, level_i} : ntot_q;
  assign node_done  = in_node && ((pin_n >= cpn) || last);

  // Max rule for wide nodes, doubled mean otherwise (a cut pair doubles its byte).
  always_comb begin
    if (cpn >= lfns_pkg::CntW'(3))      bright = {npk_n, 1'b0};
    else if (pin_n >= lfns_pkg::CntW'(2)) bright = ntot_n;
    else                                bright = {ntot_n[7:0], 1'b0};
  end

  always_comb begin
    act_d  = act_q + ((level_i > geom_i.threshold) ? 13'd1 : 13'd0);
    lsum_d = lsum_q + {12'd0, level_i};
    pk_d   = (level_i > pk_q) ? level_i : pk_q;
    pos_d  = pos_q + lfns_pkg::PosW'(1);
    nidx_d = nidx_q;
    pin_d  = pin_q;
    npk_d  = npk_q;
    ntot_d = ntot_q;
    if (in_node) begin
      if (node_done) begin
        nidx_d = nidx_q + lfns_pkg::NcW'(1);
        pin_d  = '0;
        npk_d  = '0;
        ntot_d = '0;
      end else begin
        pin_d  = pin_n[lfns_pkg::PosW-1:0];
        npk_d  = npk_n;
        ntot_d = ntot_n;
      end
    end
  end

  always_comb begin
    q_push_o                = acc && (node_done || last);
    q_ent_o.node_vld        = node_done;
    q_ent_o.bright          = bright;
    q_ent_o.idx             = nidx_q[lfns_pkg::IdxW-1:0];
    q_ent_o.frame_end       = last;
    q_ent_o.active_channels = act_d;
    q_ent_o.level_sum       = lsum_d;
    q_ent_o.peak_level      = pk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nidx_q <= '0;
      pin_q  <= '0;
      npk_q  <= '0;
      ntot_q <= '0;
      act_q  <= '0;
      lsum_q <= '0;
      pk_q   <= '0;
    end else if (clear_i || (acc && last)) begin
      pos_q  <= '0;
      nidx_q <= '0;
      pin_q  <= '0;
      npk_q  <= '0;
      ntot_q <= '0;
      act_q  <= '0;
      lsum_q <= '0;
      pk_q   <= '0;
    end else if (acc) begin
      pos_q  <= pos_d;
      nidx_q <= nidx_d;
      pin_q  <= pin_d;
      npk_q  <= npk_d;
      ntot_q <= ntot_d;
      act_q  <= act_d;
      lsum_q <= lsum_d;
      pk_q   <= pk_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lfns_queue.sv]
// Short FIFO of node / frame-end records between front and back.
// Depends on lfns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfns_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire logic            push_i,
  input  wire lfns_pkg::qent_t push_ent_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output lfns_pkg::qent_t      head_o
);

  lfns_pkg::qent_t             ent_q [lfns_pkg::QDepth];
  logic [lfns_pkg::QPtrW-1:0]  wptr_q, rptr_q;
  logic [lfns_pkg::QPtrW:0]    cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = cnt_q == (lfns_pkg::QPtrW+1)'(lfns_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + (lfns_pkg::QPtrW+1)'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - (lfns_pkg::QPtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else if (clear_i) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + lfns_pkg::QPtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + lfns_pkg::QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wptr_q] <= push_ent_i;
  end

endmodule

`default_nettype wire

[rtl/core/lfns_back.sv]
// Back end: node history memory, weighted product, run tracking and
// per-frame result register. Depends on lfns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfns_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire logic [7:0]      threshold_i,
  input  wire logic            q_empty_i,
  input  wire lfns_pkg::qent_t q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lfns_pkg::res_t       res_o
);

  logic [lfns_pkg::BriW-1:0] hist_mem [lfns_pkg::MaxNodes];

  logic                      stall, adv;

  // stage 1: history read, activity, product
  logic                      s1_vld_q;
  lfns_pkg::qent_t           s1_ent_q;
  logic                      s1_act_q;
  logic [18:0]               s1_prod_q;
  logic [lfns_pkg::BriW-1:0] prev_q;

  // frame accumulators
  logic [10:0] nact_q, nact_d;
  logic [18:0] bsum_q, bsum_d;
  logic [27:0] wsum_q, wsum_d;
  logic [9:0]  runs_q, runs_d, runs_f;
  logic [10:0] long_q, long_d, long_f;
  logic [10:0] cur_q, cur_d;
  logic [18:0] chg_q, chg_d;
  logic        hv_q;
  logic [15:0] fcnt_q;

  logic [lfns_pkg::BriW-1:0] diff;
  logic                      s2_end;

  lfns_pkg::res_t            res_q, res_d;
  logic                      out_valid_q;

  assign stall   = out_valid_q && !out_ready_i;
  assign adv     = !stall;
  assign q_pop_o = adv && !q_empty_i;
  assign s2_end  = s1_vld_q && s1_ent_q.frame_end;

  // Read-before-write keeps back-to-back frames on the same node correct.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prev_q <= hist_mem[q_head_i.idx];
      if (q_head_i.node_vld) hist_mem[q_head_i.idx] <= q_head_i.bright;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_ent_q  <= q_head_i;
      s1_act_q  <= q_head_i.bright > {threshold_i, 1'b0};
      s1_prod_q <= 19'(q_head_i.bright * q_head_i.idx);
    end
  end

  always_comb begin
    diff   = (s1_ent_q.bright > prev_q) ? s1_ent_q.bright - prev_q
                                        : prev_q - s1_ent_q.bright;
    nact_d = nact_q;
    bsum_d = bsum_q;
    wsum_d = wsum_q;
    runs_d = runs_q;
    long_d = long_q;
    cur_d  = cur_q;
    chg_d  = chg_q;
    if (s1_vld_q && s1_ent_q.node_vld) begin
      bsum_d = bsum_q + {10'd0, s1_ent_q.bright};
      if (hv_q) chg_d = chg_q + {10'd0, diff};
      if (s1_act_q) begin
        nact_d = nact_q + 11'd1;
        wsum_d = wsum_q + {9'd0, s1_prod_q};
        cur_d  = cur_q + 11'd1;
      end else if (cur_q != '0) begin
        runs_d = runs_q + 10'd1;
        long_d = (cur_q > long_q) ? cur_q : long_q;
        cur_d  = '0;
      end
    end
    // a run still open at frame end closes here
    runs_f = runs_d;
    long_f = long_d;
    if (cur_d != '0) begin
      runs_f = runs_d + 10'd1;
      long_f = (cur_d > long_d) ? cur_d : long_d;
    end

    res_d.frame_number          = fcnt_q;
    res_d.active_channels       = s1_ent_q.active_channels;
    res_d.level_sum             = s1_ent_q.level_sum;
    res_d.peak_level            = s1_ent_q.peak_level;
    res_d.active_nodes          = nact_d;
    res_d.brightness_sum        = bsum_d;
    res_d.weighted_position_sum = wsum_d;
    res_d.run_count             = runs_f;
    res_d.longest_run           = long_f;
    res_d.change_sum            = hv_q ? chg_d : '0;
    res_d.change_valid          = hv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      nact_q   <= '0;
      bsum_q   <= '0;
      wsum_q   <= '0;
      runs_q   <= '0;
      long_q   <= '0;
      cur_q    <= '0;
      chg_q    <= '0;
      hv_q     <= 1'b0;
      fcnt_q   <= '0;
    end else if (clear_i) begin
      s1_vld_q <= 1'b0;
      nact_q   <= '0;
      bsum_q   <= '0;
      wsum_q   <= '0;
      runs_q   <= '0;
      long_q   <= '0;
      cur_q    <= '0;
      chg_q    <= '0;
      hv_q     <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= q_pop_o;
      if (s2_end) begin
        nact_q <= '0;
        bsum_q <= '0;
        wsum_q <= '0;
        runs_q <= '0;
        long_q <= '0;
        cur_q  <= '0;
        chg_q  <= '0;
        hv_q   <= 1'b1;
        fcnt_q <= fcnt_q + 16'd1;
      end else begin
        nact_q <= nact_d;
        bsum_q <= bsum_d;
        wsum_q <= wsum_d;
        runs_q <= runs_d;
        long_q <= long_d;
        cur_q  <= cur_d;
        chg_q  <= chg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s2_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_end) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[rtl/core/light_frame_node_statistics.sv]
// Top level: configuration registers, front end, record queue, back end.
// Depends on lfns_pkg, lfns_front, lfns_queue, lfns_back.
//
//   channel | direction | handshake                  | payload
//   cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o    | level_i
//   out     | out       | out_valid_o / out_ready_i  | frame_number_o .. change_valid_o
//
// One channel beat per cycle while the queue has room; the front end pushes its record combinationally.
// The frame result follows the frame's last beat through these registers in order
// (queue head -> history read stage -> result register); a held result can delay it.
// A held result stalls the back end; the 4-entry queue keeps taking beats until full, then the input stalls.
// Reset: no frame in progress, no history, geometry 3/1/3, threshold 8.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module light_frame_node_statistics (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      frame_number_o,
  output logic [12:0]      active_channels_o,
  output logic [19:0]      level_sum_o,
  output logic [7:0]       peak_level_o,
  output logic [10:0]      active_nodes_o,
  output logic [18:0]      brightness_sum_o,
  output logic [27:0]      weighted_position_sum_o,
  output logic [9:0]       run_count_o,
  output logic [10:0]      longest_run_o,
  output logic [18:0]      change_sum_o,
  output logic             change_valid_o
);

  lfns_pkg::geom_t  geom_q;
  logic             cfg_we, geom_clear;
  logic             q_push, q_full, q_pop, q_empty;
  lfns_pkg::qent_t  q_in, q_head;
  lfns_pkg::res_t   res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    geom_clear = 1'b0;
    case (lfns_pkg::cfg_idx_e'(cfg_index_i))
      lfns_pkg::CfgChannelCount,
      lfns_pkg::CfgNodeCount,
      lfns_pkg::CfgChannelsPerNode: geom_clear = cfg_we;
      default:                      geom_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.channel_count     <= 13'd3;
      geom_q.node_count        <= 11'd1;
      geom_q.channels_per_node <= 13'd3;
      geom_q.threshold         <= 8'd8;
    end else if (cfg_we) begin
      case (lfns_pkg::cfg_idx_e'(cfg_index_i))
        lfns_pkg::CfgChannelCount:    geom_q.channel_count     <= cfg_data_i;
        lfns_pkg::CfgNodeCount:       geom_q.node_count        <= cfg_data_i[10:0];
        lfns_pkg::CfgChannelsPerNode: geom_q.channels_per_node <= cfg_data_i;
        lfns_pkg::CfgThreshold:       geom_q.threshold         <= cfg_data_i[7:0];
        default:                      geom_q                   <= geom_q;
      endcase
    end
  end

  lfns_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom_q),
    .clear_i    (geom_clear),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .level_i    (level_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_ent_o    (q_in)
  );

  lfns_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (geom_clear),
    .push_i     (q_push),
    .push_ent_i (q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  lfns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (geom_clear),
    .threshold_i (geom_q.threshold),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign frame_number_o          = res.frame_number;
  assign active_channels_o       = res.active_channels;
  assign level_sum_o             = res.level_sum;
  assign peak_level_o            = res.peak_level;
  assign active_nodes_o          = res.active_nodes;
  assign brightness_sum_o        = res.brightness_sum;
  assign weighted_position_sum_o = res.weighted_position_sum;
  assign run_count_o             = res.run_count;
  assign longest_run_o           = res.longest_run;
  assign change_sum_o            = res.change_sum;
  assign change_valid_o          = res.change_valid;

endmodule

`default_nettype wire

[rtl/core/lfns_checker.sv]
// Port-level checks on the frame result channel, bound to the top level.
// Depends on light_frame_node_statistics only through its ports.
`timescale 1ns / 1ps
`default_nettype none

module lfns_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] frame_number_o,
  input wire logic [19:0] level_sum_o,
  input wire logic [7:0]  peak_level_o,
  input wire logic [10:0] active_nodes_o,
  input wire logic [9:0]  run_count_o,
  input wire logic [10:0] longest_run_o,
  input wire logic [18:0] change_sum_o,
  input wire logic        change_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_number_o))
    else $error("result beat dropped or changed while stalled");

  a_change_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !change_valid_o |-> change_sum_o == '0)
    else $error("change sum without history");

  a_peak_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_sum_o >= {12'd0, peak_level_o})
    else $error("peak level exceeds level sum");

  a_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> longest_run_o <= active_nodes_o
                    && {1'b0, run_count_o} <= active_nodes_o
                    && (run_count_o == '0) == (longest_run_o == '0))
    else $error("run statistics inconsistent with active nodes");

endmodule

bind light_frame_node_statistics lfns_checker u_lfns_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_number_o (frame_number_o),
  .level_sum_o    (level_sum_o),
  .peak_level_o   (peak_level_o),
  .active_nodes_o (active_nodes_o),
  .run_count_o    (run_count_o),
  .longest_run_o  (longest_run_o),
  .change_sum_o   (change_sum_o),
  .change_valid_o (change_valid_o)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for light_frame_node_statistics: per-frame channel and node stats.
// Depends on lfns_pkg and the RTL under rtl/core; it predicts frame results in-line or takes them from typed steps.
`timescale 1ns / 1ps

module testbench;

  localparam int SettleCycles = 12;    // covers front stage, queue and result register
  localparam int HoldCycles   = 600;
  localparam int WatchLimit   = 5000;

  // one directed step: a register write or a level beat, optionally with a typed result
  typedef struct packed {
    bit                  is_write;
    lfns_pkg::cfg_idx_e  idx;
    logic [12:0]         data;
    logic [7:0]          lvl;
    bit                  typed;
    lfns_pkg::res_t      want;
  } step_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [12:0] cfg_data_i  = 13'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  level_i     = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] frame_number_o;
  logic [12:0] active_channels_o;
  logic [19:0] level_sum_o;
  logic [7:0]  peak_level_o;
  logic [10:0] active_nodes_o;
  logic [18:0] brightness_sum_o;
  logic [27:0] weighted_position_sum_o;
  logic [9:0]  run_count_o;
  logic [10:0] longest_run_o;
  logic [18:0] change_sum_o;
  logic        change_valid_o;

  light_frame_node_statistics i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Frame statistics predictor: register copies, frame walk state, node history.
  logic [12:0] cc_reg  = 13'd3;
  logic [10:0] nc_reg  = 11'd1;
  logic [12:0] cpn_reg = 13'd3;
  logic [7:0]  thr_reg = 8'd8;

  int unsigned fs_pos, fs_node, fs_in_node, fs_node_peak, fs_node_total, fs_run;
  int unsigned acc_act_ch, acc_level, acc_peak, acc_act_nodes, acc_bright;
  int unsigned acc_weight, acc_runs, acc_longest, acc_change;
  logic [15:0] frames_done = 16'd0;
  logic [8:0]  prior_bright [lfns_pkg::MaxNodes];
  bit          prior_ok = 1'b0;

  lfns_pkg::res_t frame_q [$];
  int   errors = 0;
  int   results_seen = 0;
  int   levels_sent = 0;
  int   writes_done = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   hold_reqs = 0;

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_frame_stats();
    fs_pos = 0; fs_node = 0; fs_in_node = 0;
    fs_node_peak = 0; fs_node_total = 0; fs_run = 0;
    acc_act_ch = 0; acc_level = 0; acc_peak = 0; acc_act_nodes = 0; acc_bright = 0;
    acc_weight = 0; acc_runs = 0; acc_longest = 0; acc_change = 0;
  endfunction

  function automatic void close_active_run();
    if (fs_run > 0) begin
      acc_runs++;
      if (fs_run > acc_longest) acc_longest = fs_run;
      fs_run = 0;
    end
  endfunction

  function automatic void close_node(int unsigned cpn);
    int unsigned b;
    int unsigned prev;
    if (cpn >= 3) b = 2 * fs_node_peak;
    else if (fs_in_node >= 2) b = fs_node_total;
    else b = 2 * fs_node_total;
    acc_bright += b;
    if (b > 2 * thr_reg) begin
      acc_act_nodes++;
      acc_weight += b * fs_node;
      fs_run++;
    end else begin
      close_active_run();
    end
    if (fs_node < lfns_pkg::MaxNodes) begin
      if (prior_ok) begin
        prev = prior_bright[fs_node];
        acc_change += (b > prev) ? (b - prev) : (prev - b);
      end
      prior_bright[fs_node] = 9'(b);
    end
    fs_node++;
    fs_in_node = 0;
    fs_node_peak = 0;
    fs_node_total = 0;
  endfunction

  // Returns 1 when this beat closes a frame, with the frame result in r.
  function automatic bit accept_level(input logic [7:0] lvl, output lfns_pkg::res_t r);
    int unsigned cc, nc, cpn;
    bit last;
    cc  = clamp_cfg(cc_reg, lfns_pkg::MaxChannels);
    nc  = clamp_cfg(nc_reg, lfns_pkg::MaxNodes);
    cpn = clamp_cfg(cpn_reg, lfns_pkg::MaxChannels);
    last = (fs_pos + 1 >= cc);
    r = '0;
    if (lvl > thr_reg) acc_act_ch++;
    acc_level += lvl;
    if (lvl > acc_peak) acc_peak = lvl;
    if (fs_node < nc) begin
      if (lvl > fs_node_peak) fs_node_peak = lvl;
      if (cpn < 3) fs_node_total += lvl;
      fs_in_node++;
      if (fs_in_node >= cpn || last) close_node(cpn);
    end
    fs_pos++;
    if (!last) return 1'b0;
    close_active_run();
    r.frame_number          = frames_done;
    r.active_channels       = 13'(acc_act_ch);
    r.level_sum             = 20'(acc_level);
    r.peak_level            = 8'(acc_peak);
    r.active_nodes          = 11'(acc_act_nodes);
    r.brightness_sum        = 19'(acc_bright);
    r.weighted_position_sum = 28'(acc_weight);
    r.run_count             = 10'(acc_runs);
    r.longest_run           = 11'(acc_longest);
    r.change_sum            = prior_ok ? 19'(acc_change) : 19'd0;
    r.change_valid          = prior_ok;
    frames_done++;
    prior_ok = 1'b1;
    clear_frame_stats();
    return 1'b1;
  endfunction

  function automatic void apply_write(lfns_pkg::cfg_idx_e idx, logic [12:0] d);
    case (idx)
      lfns_pkg::CfgChannelCount:    cc_reg  = d;
      lfns_pkg::CfgNodeCount:       nc_reg  = d[10:0];
      lfns_pkg::CfgChannelsPerNode: cpn_reg = d;
      lfns_pkg::CfgThreshold:       thr_reg = d[7:0];
      default: ;
    endcase
    // geometry changes drop the partial frame and the node history
    if (idx != lfns_pkg::CfgThreshold) begin
      clear_frame_stats();
      prior_ok = 1'b0;
    end
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return thr_reg;
      3: return thr_reg + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: random stalls, plus long hold-offs requested by the sender.
  int hold_taken = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_reqs != hold_taken) begin
      hold_taken  <= hold_reqs;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void check_field(string name, logic [15:0] frame,
                                      logic [27:0] want, logic [27:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: frame %0d %s expected %0d got %0d", $time, frame, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    lfns_pkg::res_t got;
    lfns_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {frame_number_o, active_channels_o, level_sum_o, peak_level_o, active_nodes_o,
             brightness_sum_o, weighted_position_sum_o, run_count_o, longest_run_o,
             change_sum_o, change_valid_o};
      if (frame_q.size() == 0) begin
        errors++;
        $display("%0t: frame result with none pending, expected none got frame %0d",
                 $time, got.frame_number);
      end else begin
        want = frame_q.pop_front();
        results_seen++;
        check_field("frame_number", want.frame_number, want.frame_number, got.frame_number);
        check_field("active_channels", want.frame_number, want.active_channels,
                    got.active_channels);
        check_field("level_sum", want.frame_number, want.level_sum, got.level_sum);
        check_field("peak_level", want.frame_number, want.peak_level, got.peak_level);
        check_field("active_nodes", want.frame_number, want.active_nodes, got.active_nodes);
        check_field("brightness_sum", want.frame_number, want.brightness_sum,
                    got.brightness_sum);
        check_field("weighted_position_sum", want.frame_number, want.weighted_position_sum,
                    got.weighted_position_sum);
        check_field("run_count", want.frame_number, want.run_count, got.run_count);
        check_field("longest_run", want.frame_number, want.longest_run, got.longest_run);
        check_field("change_sum", want.frame_number, want.change_sum, got.change_sum);
        check_field("change_valid", want.frame_number, want.change_valid, got.change_valid);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("%0t: no beat moved for %0d cycles, %0d results pending",
               $time, WatchLimit, frame_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic set_idle(int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 62; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 62; end
      default: begin gap_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // Offers one level beat and returns at the edge where it is taken; valid stays up.
  task automatic put_level(input logic [7:0] lvl);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    levels_sent++;
  endtask

  task automatic send_level(input logic [7:0] lvl);
    lfns_pkg::res_t want;
    put_level(lvl);
    if (accept_level(lvl, want)) frame_q = {frame_q, want};
  endtask

  // Stop offering, wait for every pending result, then let the pipeline drain.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(lfns_pkg::cfg_idx_e idx, logic [12:0] d);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_write(idx, d);
    writes_done++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_geometry(int unsigned cc, int unsigned nc, int unsigned cpn);
    write_reg(lfns_pkg::CfgChannelCount, 13'(cc));
    write_reg(lfns_pkg::CfgNodeCount, 13'(nc));
    write_reg(lfns_pkg::CfgChannelsPerNode, 13'(cpn));
  endtask

  function automatic step_t lv(logic [7:0] v);
    step_t s;
    s = '0;
    s.lvl = v;
    return s;
  endfunction

  function automatic step_t lv_is(logic [7:0] v, lfns_pkg::res_t w);
    step_t s;
    s = lv(v);
    s.typed = 1'b1;
    s.want = w;
    return s;
  endfunction

  function automatic step_t wr(lfns_pkg::cfg_idx_e i, logic [12:0] d);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.idx = i;
    s.data = d;
    return s;
  endfunction

  step_t stim_rows [$];

  initial begin
    lfns_pkg::res_t want;
    int unsigned g_cc, g_nc, g_cpn;
    logic [12:0] g_thr;
    int n;

    clear_frame_stats();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stim_rows = {
      // reset geometry 3/1/3, threshold 8: dark frame, then full-scale frame
      lv(8'd0), lv(8'd0), lv_is(8'd0, lfns_pkg::res_t'('0)),
      lv(8'd255), lv(8'd255),
      lv_is(8'd255, lfns_pkg::res_t'{16'd1, 13'd3, 20'd765, 8'd255, 11'd1, 19'd510,
                                     28'd0, 10'd1, 11'd1, 19'd510, 1'b1}),
      // zero registers act as 1; threshold at max leaves nothing active
      wr(lfns_pkg::CfgChannelCount, 13'd0), wr(lfns_pkg::CfgNodeCount, 13'd0),
      wr(lfns_pkg::CfgChannelsPerNode, 13'd0), wr(lfns_pkg::CfgThreshold, 13'd255),
      lv_is(8'd255, lfns_pkg::res_t'{16'd2, 13'd0, 20'd255, 8'd255, 11'd0, 19'd510,
                                     28'd0, 10'd0, 11'd0, 19'd0, 1'b0}),
      // threshold write keeps history
      wr(lfns_pkg::CfgThreshold, 13'd0),
      lv_is(8'd1, lfns_pkg::res_t'{16'd3, 13'd1, 20'd1, 8'd1, 11'd1, 19'd2, 28'd0,
                                   10'd1, 11'd1, 19'd508, 1'b1}),
      // two-channel nodes with the last one cut short, node count over the bound
      wr(lfns_pkg::CfgChannelCount, 13'd3), wr(lfns_pkg::CfgNodeCount, 13'd2047),
      wr(lfns_pkg::CfgChannelsPerNode, 13'd2), wr(lfns_pkg::CfgThreshold, 13'd8),
      lv(8'd10), lv(8'd20), lv(8'd7),
      // cut peak node and a node past the frame end
      wr(lfns_pkg::CfgChannelCount, 13'd5), wr(lfns_pkg::CfgChannelsPerNode, 13'd3),
      wr(lfns_pkg::CfgNodeCount, 13'd4),
      lv(8'd255), lv(8'd0), lv(8'd9), lv(8'd200), lv(8'd3),
      // partial frame dropped by a geometry write; then channels past the nodes
      lv(8'd50), lv(8'd60), wr(lfns_pkg::CfgChannelCount, 13'd4),
      wr(lfns_pkg::CfgNodeCount, 13'd1),
      lv(8'd9), lv(8'd8), lv(8'd255), lv(8'd17)
    };

    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_write) begin
        write_reg(stim_rows[k].idx, stim_rows[k].data);
      end else begin
        put_level(stim_rows[k].lvl);
        if (accept_level(stim_rows[k].lvl, want)) begin
          if (stim_rows[k].typed) want = stim_rows[k].want;
          frame_q = {frame_q, want};
        end
      end
    end

    // random frames over a spread of geometries and idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      set_idle(ph % 4);
      if (ph % 3 == 2) begin
        write_reg(lfns_pkg::CfgThreshold, 13'($urandom_range(0, 8191)));
      end else begin
        case ($urandom_range(0, 9))
          0: g_cc = 0;
          1: g_cc = 1;
          2: g_cc = 2;
          default: g_cc = $urandom_range(3, 40);
        endcase
        case ($urandom_range(0, 7))
          0: g_nc = 0;
          1: g_nc = 2047;
          2: g_nc = 1024;
          default: g_nc = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 9))
          0: g_cpn = 0;
          1: g_cpn = 1;
          2: g_cpn = 2;
          3: g_cpn = 3;
          4: g_cpn = 8191;
          default: g_cpn = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 5))
          0: g_thr = 13'd0;
          1: g_thr = 13'd255;
          default: g_thr = 13'($urandom_range(0, 8191));
        endcase
        program_geometry(g_cc, g_nc, g_cpn);
        write_reg(lfns_pkg::CfgThreshold, g_thr);
      end
      n = 0;
      do begin
        send_level(pick_level());
        n++;
        if (n == 30 && fs_pos != 0) begin
          if (ph % 3 == 2) begin
            write_reg(lfns_pkg::CfgThreshold, 13'($urandom_range(0, 255)));
          end else if (ph % 4 == 1) begin
            write_reg(lfns_pkg::CfgChannelCount, 13'($urandom_range(1, 40)));
          end
        end
      end while (n < 60 || fs_pos != 0);
    end

    // long output hold-off with one-beat frames: the block fills and stalls its input
    set_idle(0);
    program_geometry(1, 1, 1);
    hold_reqs++;
    repeat (80) send_level(pick_level());

    quiesce();
    $display("Run moved %0d level beats and %0d register writes, checking %0d frame results,",
             levels_sent, writes_done, results_seen);
    $display("across varied geometries and idle patterns, a long output hold-off and drains.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
